[sv/btag_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btag_pkg
// Shared types and codes for the boundary-tag allocator.
// ----------------------------------------------------------------------------
package btag_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_NOFIT = 1'b1;

    localparam int CFG_W   = 11;
    localparam int BYTES_W = 15;
    localparam int INDEX_W = 10;
    localparam int DIV_W   = 16;

    typedef enum logic [5:0] {
        ST_CLR, ST_IDLE, ST_DIV, ST_AST, ST_ARD, ST_ACHK,
        ST_NS1, ST_NS2, ST_NS3, ST_SP1, ST_SP2, ST_SP3,
        ST_F1, ST_F2, ST_F3, ST_FSEL, ST_G1, ST_G2,
        ST_B1, ST_B2, ST_B3, ST_B4,
        ST_C1, ST_C2, ST_C3,
        ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6, ST_D7,
        ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_E7, ST_E8, ST_E9,
        ST_DONE
    } t_state;

endpackage

[sv/btag_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btag_ram
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
module btag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/boundary_tag_allocator_unit.sv]
`timescale 1ns / 1ps
// Allocate sizes the request by one reciprocal multiply, reads each free-list node visited,
//   then updates the tags and hands the word to the output register; an allocate on an
//   empty list answers without walking the list.
// The tag updates of a free depend on which neighbors merge.
// One word is handled at a time; the single read port of each tag memory sets the pace.
//   A result word held in the output register stalls the next one in ST_DONE.
// Reset: synchronous active-low; afterwards a clearing pass sweeps every word of the tag
//   memories, and no word is accepted until it ends (config writes are still taken).
// ----------------------------------------------------------------------------
// boundary_tag_allocator_unit
// First-fit boundary-tag allocator over a word store with a roving free-list head.
// ----------------------------------------------------------------------------
module boundary_tag_allocator_unit #(
    parameter int MEM_WORDS  = 1024,
    parameter int WORD_BYTES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic [btag_pkg::BYTES_W-1:0] i_request_bytes,
    input  logic [btag_pkg::INDEX_W-1:0] i_block_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_status,
    output logic [btag_pkg::INDEX_W-1:0] o_granted_index,
    input  logic                         i_cfg_we,
    input  logic [btag_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import btag_pkg::*;

    localparam int AW  = $clog2(MEM_WORDS);
    localparam int SW  = $clog2(MEM_WORDS + 1);
    localparam int NW  = DIV_W + 1;
    // Reciprocal of the word size, rounded up, exact for every DIV_W-bit dividend.
    localparam int DSH = $clog2(WORD_BYTES);
    localparam int PW  = 2 * DIV_W + 1;
    localparam longint RECIP =
        ((longint'(1) << (DIV_W + DSH)) + longint'(WORD_BYTES) - 1) / longint'(WORD_BYTES);

    // Foot word of a block: saturate into the store, size zero counts as one.
    function automatic logic [AW-1:0] f_foot(input logic [AW-1:0] p, input logic [SW-1:0] s);
        logic [AW+1:0] e;
        e = (AW+2)'(p) + ((s == '0) ? (AW+2)'(1) : (AW+2)'(s)) - (AW+2)'(1);
        if (e >= (AW+2)'(MEM_WORDS)) begin
            e = (AW+2)'(MEM_WORDS - 1);
        end
        return e[AW-1:0];
    endfunction

    function automatic logic [SW-1:0] f_sat(input logic [SW+1:0] v);
        return (v > (SW+2)'(MEM_WORDS)) ? SW'(MEM_WORDS) : v[SW-1:0];
    endfunction

    // Tag memories
    logic          lu_we, rl_we, ot_we, bw_we;
    logic [AW-1:0] lu_wa, rl_wa, ot_wa, bw_wa;
    logic [AW-1:0] lu_wd, rl_wd;
    logic          ot_wd;
    logic [SW-1:0] bw_wd;
    logic [AW-1:0] lu_ra, rl_ra, ot_ra, bw_ra;
    logic [AW-1:0] lu_rd, rl_rd;
    logic          ot_rd;
    logic [SW-1:0] bw_rd;

    btag_ram #(.WIDTH(AW), .DEPTH(MEM_WORDS)) u_lu (
        .i_clk(i_clk), .i_we(lu_we), .i_waddr(lu_wa), .i_wdata(lu_wd),
        .i_raddr(lu_ra), .o_rdata(lu_rd));
    btag_ram #(.WIDTH(AW), .DEPTH(MEM_WORDS)) u_rl (
        .i_clk(i_clk), .i_we(rl_we), .i_waddr(rl_wa), .i_wdata(rl_wd),
        .i_raddr(rl_ra), .o_rdata(rl_rd));
    btag_ram #(.WIDTH(1), .DEPTH(MEM_WORDS)) u_ot (
        .i_clk(i_clk), .i_we(ot_we), .i_waddr(ot_wa), .i_wdata(ot_wd),
        .i_raddr(ot_ra), .o_rdata(ot_rd));
    btag_ram #(.WIDTH(SW), .DEPTH(MEM_WORDS)) u_bw (
        .i_clk(i_clk), .i_we(bw_we), .i_waddr(bw_wa), .i_wdata(bw_wd),
        .i_raddr(bw_ra), .o_rdata(bw_rd));

    // Control registers
    t_state         r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic [AW-1:0]  r_fh, n_fh;
    logic           r_empty, n_empty;
    logic [CFG_W-1:0] r_thr, n_thr;
    logic           r_out_valid, n_out_valid;

    // Working registers
    logic [AW-1:0]  r_p, n_p, r_rl, n_rl, r_f, n_f, r_t, n_t, r_fp, n_fp;
    logic [AW-1:0]  r_s, n_s, r_q, n_q, r_grant, n_grant;
    logic [NW-1:0]  r_n, n_n;
    logic [AW:0]    r_steps, n_steps;
    logic [SW-1:0]  r_bw, n_bw, r_rem, n_rem;
    logic           r_l, n_l, r_r, n_r, r_status, n_status;
    logic [DIV_W-1:0] r_dq, n_dq;
    logic           r_out_status, n_out_status;
    logic [AW-1:0]  r_out_grant, n_out_grant;

    logic [PW-1:0]  c_prod;
    logic [AW+1:0]  c_ri;
    logic [SW-1:0]  c_left;

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_fh = r_fh; n_empty = r_empty;
        n_thr = r_thr; n_out_valid = r_out_valid;
        n_p = r_p; n_rl = r_rl; n_f = r_f; n_t = r_t; n_fp = r_fp; n_s = r_s; n_q = r_q;
        n_grant = r_grant; n_n = r_n; n_steps = r_steps; n_bw = r_bw; n_rem = r_rem;
        n_l = r_l; n_r = r_r; n_status = r_status; n_dq = r_dq;
        n_out_status = r_out_status; n_out_grant = r_out_grant;
        lu_we = 1'b0; lu_wa = r_p; lu_wd = r_p; lu_ra = r_p;
        rl_we = 1'b0; rl_wa = r_p; rl_wd = r_p; rl_ra = r_p;
        ot_we = 1'b0; ot_wa = r_p; ot_wd = 1'b0; ot_ra = r_p;
        bw_we = 1'b0; bw_wa = r_p; bw_wd = r_bw; bw_ra = r_p;
        c_prod = PW'(r_dq) * PW'(RECIP);
        c_ri = (AW+2)'(r_p) + (AW+2)'(bw_rd);
        c_left = bw_rd - SW'(r_n);

        if (i_cfg_we) begin
            n_thr = i_cfg_wdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLR: begin
                lu_we = 1'b1; lu_wa = r_clr; lu_wd = '0;
                rl_we = 1'b1; rl_wa = r_clr; rl_wd = '0;
                ot_we = 1'b1; ot_wa = r_clr; ot_wd = 1'b0;
                bw_we = 1'b1; bw_wa = r_clr;
                bw_wd = (r_clr == '0) ? SW'(MEM_WORDS) : '0;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(MEM_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_ALLOC) begin
                        n_dq = DIV_W'(i_request_bytes) + DIV_W'(WORD_BYTES - 1);
                        n_state = ST_DIV;
                    end else if (32'(i_block_index) >= 32'(MEM_WORDS)) begin
                        n_status = STATUS_DONE; n_grant = '0; n_state = ST_DONE;
                    end else begin
                        n_p = AW'(i_block_index);
                        n_state = ST_F1;
                    end
                end
            end
            // Word count by reciprocal multiply, rounded up through the bias added above.
            ST_DIV: begin
                n_dq = DIV_W'(c_prod >> (DIV_W + DSH));
                n_state = ST_AST;
            end
            ST_AST: begin
                n_n = NW'(r_dq) + NW'(2);
                n_p = r_fh;
                n_steps = (AW+1)'(1);
                if (r_empty) begin
                    n_status = STATUS_NOFIT; n_grant = '0; n_state = ST_DONE;
                end else begin
                    n_state = ST_ARD;
                end
            end
            ST_ARD: begin
                bw_ra = r_p; rl_ra = r_p;
                n_state = ST_ACHK;
            end
            ST_ACHK: begin
                if (NW'(bw_rd) >= r_n) begin
                    n_bw = bw_rd; n_rl = rl_rd;
                    n_f = f_foot(r_p, bw_rd);
                    n_rem = c_left;
                    n_state = (32'(c_left) <= 32'(r_thr)) ? ST_NS1 : ST_SP1;
                end else if (rl_rd == r_fh || r_steps >= (AW+1)'(MEM_WORDS)) begin
                    n_status = STATUS_NOFIT; n_grant = '0; n_state = ST_DONE;
                end else begin
                    n_p = rl_rd;
                    n_steps = r_steps + (AW+1)'(1);
                    n_state = ST_ARD;
                end
            end
            // Whole block taken: unlink it.
            ST_NS1: begin
                ot_we = 1'b1; ot_wa = r_p; ot_wd = 1'b1;
                if (r_rl == r_p) begin
                    n_empty = 1'b1; n_fh = '0; n_state = ST_NS3;
                end else begin
                    lu_ra = r_p; n_fh = r_rl; n_state = ST_NS2;
                end
            end
            ST_NS2: begin
                lu_we = 1'b1; lu_wa = r_rl; lu_wd = lu_rd;
                rl_we = 1'b1; rl_wa = lu_rd; rl_wd = r_rl;
                n_state = ST_NS3;
            end
            ST_NS3: begin
                ot_we = 1'b1; ot_wa = r_f; ot_wd = 1'b1;
                n_status = STATUS_DONE; n_grant = r_p; n_state = ST_DONE;
            end
            // Carve the request from the top of the block.
            ST_SP1: begin
                ot_we = 1'b1; ot_wa = r_f; ot_wd = 1'b1;
                bw_we = 1'b1; bw_wa = r_p; bw_wd = r_rem;
                n_f = f_foot(r_p, r_rem);
                n_fh = r_rl;
                n_state = ST_SP2;
            end
            ST_SP2: begin
                ot_we = 1'b1; ot_wa = r_f; ot_wd = 1'b0;
                lu_we = 1'b1; lu_wa = r_f; lu_wd = r_p;
                n_p = (r_f == AW'(MEM_WORDS - 1)) ? '0 : r_f + AW'(1);
                n_state = ST_SP3;
            end
            ST_SP3: begin
                ot_we = 1'b1; ot_wa = r_p; ot_wd = 1'b1;
                bw_we = 1'b1; bw_wa = r_p; bw_wd = SW'(r_n);
                n_status = STATUS_DONE; n_grant = r_p; n_state = ST_DONE;
            end
            // Free: look at both neighbors.
            ST_F1: begin
                ot_ra = r_p - AW'(1); bw_ra = r_p;
                n_state = ST_F2;
            end
            ST_F2: begin
                n_l = (r_p == '0) ? 1'b1 : ot_rd;
                n_bw = bw_rd;
                n_fp = f_foot(r_p, bw_rd);
                n_t = c_ri[AW-1:0];
                if (c_ri < (AW+2)'(MEM_WORDS)) begin
                    ot_ra = c_ri[AW-1:0]; n_state = ST_F3;
                end else begin
                    n_r = 1'b1; n_state = ST_FSEL;
                end
            end
            ST_F3: begin
                n_r = ot_rd; n_state = ST_FSEL;
            end
            ST_FSEL: begin
                n_status = STATUS_DONE; n_grant = '0;
                if (r_empty)            n_state = ST_G1;
                else if (r_l && r_r)    n_state = ST_B1;
                else if (!r_l && r_r)   n_state = ST_C1;
                else if (r_l && !r_r)   n_state = ST_D1;
                else                    n_state = ST_E1;
            end
            ST_G1: begin
                n_fh = r_p;
                lu_we = 1'b1; lu_wa = r_p; lu_wd = r_p;
                rl_we = 1'b1; rl_wa = r_p; rl_wd = r_p;
                ot_we = 1'b1; ot_wa = r_p; ot_wd = 1'b0;
                n_state = ST_G2;
            end
            ST_G2: begin
                ot_we = 1'b1; ot_wa = r_fp; ot_wd = 1'b0;
                lu_we = 1'b1; lu_wa = r_fp; lu_wd = r_p;
                n_empty = 1'b0; n_state = ST_DONE;
            end
            // No free neighbor: insert at the head.
            ST_B1: begin
                ot_we = 1'b1; ot_wa = r_p; ot_wd = 1'b0;
                lu_we = 1'b1; lu_wa = r_fp; lu_wd = r_p;
                n_state = ST_B2;
            end
            ST_B2: begin
                ot_we = 1'b1; ot_wa = r_fp; ot_wd = 1'b0;
                lu_ra = r_fh; n_state = ST_B3;
            end
            ST_B3: begin
                n_q = lu_rd;
                rl_we = 1'b1; rl_wa = r_p; rl_wd = r_fh;
                lu_we = 1'b1; lu_wa = r_p; lu_wd = lu_rd;
                n_state = ST_B4;
            end
            ST_B4: begin
                rl_we = 1'b1; rl_wa = r_q; rl_wd = r_p;
                lu_we = 1'b1; lu_wa = r_fh; lu_wd = r_p;
                n_fh = r_p; n_state = ST_DONE;
            end
            // Free left neighbor: grow it.
            ST_C1: begin
                ot_we = 1'b1; ot_wa = r_p; ot_wd = 1'b0;
                lu_ra = r_p - AW'(1); n_state = ST_C2;
            end
            ST_C2: begin
                n_s = lu_rd; bw_ra = lu_rd; n_state = ST_C3;
            end
            ST_C3: begin
                bw_we = 1'b1; bw_wa = r_s;
                bw_wd = f_sat((SW+2)'(bw_rd) + (SW+2)'(r_bw));
                lu_we = 1'b1; lu_wa = r_fp; lu_wd = r_s;
                ot_we = 1'b1; ot_wa = r_fp; ot_wd = 1'b0;
                n_state = ST_DONE;
            end
            // Free right neighbor: take over its list place.
            ST_D1: begin
                ot_we = 1'b1; ot_wa = r_p; ot_wd = 1'b0;
                lu_ra = r_t; n_state = ST_D2;
            end
            ST_D2: begin
                ot_we = 1'b1; ot_wa = r_fp; ot_wd = 1'b0;
                lu_we = 1'b1; lu_wa = r_p; lu_wd = lu_rd;
                rl_we = 1'b1; rl_wa = lu_rd; rl_wd = r_p;
                n_state = ST_D3;
            end
            ST_D3: begin
                rl_ra = r_t; n_state = ST_D4;
            end
            ST_D4: begin
                rl_we = 1'b1; rl_wa = r_p; rl_wd = rl_rd;
                lu_we = 1'b1; lu_wa = rl_rd; lu_wd = r_p;
                bw_ra = r_t; n_state = ST_D5;
            end
            ST_D5: begin
                bw_we = 1'b1; bw_wa = r_p;
                bw_wd = f_sat((SW+2)'(r_bw) + (SW+2)'(bw_rd));
                n_state = ST_D6;
            end
            ST_D6: begin
                bw_ra = r_t; n_state = ST_D7;
            end
            ST_D7: begin
                lu_we = 1'b1; lu_wa = f_foot(r_t, bw_rd); lu_wd = r_p;
                if (r_fh == r_t) n_fh = r_p;
                n_state = ST_DONE;
            end
            // Both neighbors free: merge all three into the left one.
            ST_E1: begin
                ot_we = 1'b1; ot_wa = r_p; ot_wd = 1'b0;
                lu_ra = r_p - AW'(1); n_state = ST_E2;
            end
            ST_E2: begin
                n_s = lu_rd;
                ot_we = 1'b1; ot_wa = r_fp; ot_wd = 1'b0;
                bw_ra = lu_rd; n_state = ST_E3;
            end
            ST_E3: begin
                n_rem = bw_rd; bw_ra = r_t; n_state = ST_E4;
            end
            ST_E4: begin
                bw_we = 1'b1; bw_wa = r_s;
                bw_wd = f_sat((SW+2)'(r_rem) + (SW+2)'(r_bw) + (SW+2)'(bw_rd));
                lu_ra = r_t; n_state = ST_E5;
            end
            ST_E5: begin
                n_q = lu_rd; rl_ra = r_t; n_state = ST_E6;
            end
            ST_E6: begin
                rl_we = 1'b1; rl_wa = r_q; rl_wd = rl_rd;
                n_state = ST_E7;
            end
            ST_E7: begin
                rl_ra = r_t; n_state = ST_E8;
            end
            ST_E8: begin
                lu_we = 1'b1; lu_wa = rl_rd; lu_wd = r_q;
                bw_ra = r_t; n_state = ST_E9;
            end
            ST_E9: begin
                lu_we = 1'b1; lu_wa = f_foot(r_t, bw_rd); lu_wd = r_s;
                if (r_fh == r_t) n_fh = r_s;
                n_state = ST_DONE;
            end
            // Hold the result until the output register is free.
            ST_DONE: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_status = r_status;
                    n_out_grant = r_grant;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr <= '0;
            r_fh <= '0;
            r_empty <= 1'b0;
            r_thr <= CFG_W'(8);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_fh <= n_fh;
            r_empty <= n_empty;
            r_thr <= n_thr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p; r_rl <= n_rl; r_f <= n_f; r_t <= n_t; r_fp <= n_fp;
        r_s <= n_s; r_q <= n_q; r_grant <= n_grant; r_n <= n_n; r_steps <= n_steps;
        r_bw <= n_bw; r_rem <= n_rem; r_l <= n_l; r_r <= n_r; r_status <= n_status;
        r_dq <= n_dq;
        r_out_status <= n_out_status; r_out_grant <= n_out_grant;
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_index = INDEX_W'(r_out_grant);
endmodule

[sv/btag_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btag_chk
// Port-level checks for the boundary-tag allocator, bound to the top level.
// ----------------------------------------------------------------------------
module btag_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_status,
    input logic [9:0] o_granted_index
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_granted_index))
        else $error("result word changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_granted_index == 10'd0)
        else $error("failed allocate shows nonzero index");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block active right after reset");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while busy");
endmodule

bind boundary_tag_allocator_unit btag_chk u_btag_chk (.*);

[bench/btag_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btag_checker
// Watches the request, result and config ports of the boundary-tag allocator.
// Keeps its own copy of the tag store, predicts each result word and compares.
// ----------------------------------------------------------------------------
module btag_checker #(
    parameter int MEM_WORDS  = 1024,
    parameter int WORD_BYTES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_cmd,
    input  logic [btag_pkg::BYTES_W-1:0] i_request_bytes,
    input  logic [btag_pkg::INDEX_W-1:0] i_block_index,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_status,
    input  logic [btag_pkg::INDEX_W-1:0] i_granted_index,
    input  logic                         i_cfg_we,
    input  logic [btag_pkg::CFG_W-1:0]   i_cfg_wdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import btag_pkg::*;

    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] granted;
    } t_grant;

    logic [INDEX_W-1:0] up_link   [MEM_WORDS];
    logic [INDEX_W-1:0] right_lnk [MEM_WORDS];
    logic               occ       [MEM_WORDS];
    logic [CFG_W-1:0]   blk_size  [MEM_WORDS];
    logic [INDEX_W-1:0] rover;
    logic               no_free;
    logic [CFG_W-1:0]   absorb_limit;

    t_grant grant_q[$];

    function automatic int foot_of(input int p);
        int s;
        int e;
        s = blk_size[p];
        if (s == 0) s = 1;
        e = p + s - 1;
        if (e >= MEM_WORDS) e = MEM_WORDS - 1;
        return e;
    endfunction

    function automatic int sat_size(input int v);
        return (v > MEM_WORDS) ? MEM_WORDS : v;
    endfunction

    // first-fit search from the rover; whole block or carve from the top
    function automatic t_grant allocate(input int bytes);
        t_grant r;
        int n, p, f, steps, left;
        r = '0;
        n = (bytes + WORD_BYTES - 1) / WORD_BYTES + 2;
        if (no_free) begin
            r.status = STATUS_NOFIT;
            return r;
        end
        p = rover;
        steps = 1;
        while (blk_size[p] < n && right_lnk[p] != rover) begin
            if (steps >= MEM_WORDS) begin
                r.status = STATUS_NOFIT;
                return r;
            end
            p = right_lnk[p];
            steps++;
        end
        if (blk_size[p] < n) begin
            r.status = STATUS_NOFIT;
            return r;
        end
        f = foot_of(p);
        rover = right_lnk[p];
        if (int'(blk_size[p]) - n <= int'(absorb_limit)) begin
            if (int'(rover) == p) begin
                no_free = 1'b1;
                rover = '0;
            end else begin
                left = up_link[p];
                up_link[rover] = INDEX_W'(left);
                right_lnk[left] = rover;
            end
            occ[p] = 1'b1;
            occ[f] = 1'b1;
        end else begin
            occ[f] = 1'b1;
            blk_size[p] = CFG_W'(int'(blk_size[p]) - n);
            f = foot_of(p);
            occ[f] = 1'b0;
            up_link[f] = INDEX_W'(p);
            p = (f + 1) % MEM_WORDS;
            occ[p] = 1'b1;
            blk_size[p] = CFG_W'(n);
        end
        r.status = STATUS_DONE;
        r.granted = INDEX_W'(p);
        return r;
    endfunction

    // return a block, merging with free neighbors on either side
    function automatic void release_block(input int p);
        int ri, s, t, q, fp, ft;
        logic l, r;
        if (p >= MEM_WORDS) return;
        l = (p == 0) ? 1'b1 : occ[p-1];
        ri = p + blk_size[p];
        r = (ri >= MEM_WORDS) ? 1'b1 : occ[ri];
        fp = foot_of(p);
        if (no_free) begin
            rover = INDEX_W'(p);
            up_link[p] = INDEX_W'(p);
            right_lnk[p] = INDEX_W'(p);
            occ[p] = 1'b0;
            occ[fp] = 1'b0;
            up_link[fp] = INDEX_W'(p);
            no_free = 1'b0;
        end else if (l && r) begin
            occ[p] = 1'b0;
            up_link[fp] = INDEX_W'(p);
            occ[fp] = 1'b0;
            q = up_link[rover];
            right_lnk[p] = rover;
            up_link[p] = INDEX_W'(q);
            right_lnk[q] = INDEX_W'(p);
            up_link[rover] = INDEX_W'(p);
            rover = INDEX_W'(p);
        end else if (!l && r) begin
            occ[p] = 1'b0;
            s = up_link[p-1];
            blk_size[s] = CFG_W'(sat_size(blk_size[s] + blk_size[p]));
            up_link[fp] = INDEX_W'(s);
            occ[fp] = 1'b0;
        end else if (l && !r) begin
            t = ri;
            occ[p] = 1'b0;
            occ[fp] = 1'b0;
            q = up_link[t];
            up_link[p] = INDEX_W'(q);
            right_lnk[q] = INDEX_W'(p);
            q = right_lnk[t];
            right_lnk[p] = INDEX_W'(q);
            up_link[q] = INDEX_W'(p);
            blk_size[p] = CFG_W'(sat_size(blk_size[p] + blk_size[t]));
            ft = foot_of(t);
            up_link[ft] = INDEX_W'(p);
            if (int'(rover) == t) rover = INDEX_W'(p);
        end else begin
            s = up_link[p-1];
            t = ri;
            occ[p] = 1'b0;
            occ[fp] = 1'b0;
            blk_size[s] = CFG_W'(sat_size(blk_size[s] + blk_size[p] + blk_size[t]));
            right_lnk[up_link[t]] = right_lnk[t];
            up_link[right_lnk[t]] = up_link[t];
            ft = foot_of(t);
            up_link[ft] = INDEX_W'(s);
            if (int'(rover) == t) rover = INDEX_W'(s);
        end
    endfunction

    task automatic report(input string what, input int want, input int got);
        $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = grant_q.size();

    always @(posedge i_clk) begin
        t_grant want;
        t_grant got;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_WORDS; i++) begin
                up_link[i] = '0;
                right_lnk[i] = '0;
                occ[i] = 1'b0;
                blk_size[i] = '0;
            end
            blk_size[0] = CFG_W'(MEM_WORDS);
            rover = '0;
            no_free = 1'b0;
            absorb_limit = CFG_W'(8);
            grant_q.delete();
        end else begin
            if (i_cfg_we) absorb_limit = i_cfg_wdata;
            // compare before predicting: a word leaving now cannot be the one entering
            if (i_out_valid && i_out_ready) begin
                got.status = i_status;
                got.granted = i_granted_index;
                if (grant_q.size() == 0) begin
                    report("unexpected result word, status", 0, got.status);
                end else begin
                    want = grant_q.pop_front();
                    if (got.status !== want.status)
                        report("status", want.status, got.status);
                    if (got.granted !== want.granted)
                        report("granted_index", want.granted, got.granted);
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = '0;
                if (i_cmd == CMD_ALLOC) want = allocate(i_request_bytes);
                else release_block(i_block_index);
                grant_q.push_back(want);
            end
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives allocate and free words into the boundary-tag allocator, frees only
// blocks it was granted, sweeps the split threshold and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import btag_pkg::*;

    localparam int MEM_WORDS   = 1024;
    localparam int CYCLE_LIMIT = 20000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_cmd;
    logic [BYTES_W-1:0] i_request_bytes;
    logic [INDEX_W-1:0] i_block_index;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_status;
    logic [INDEX_W-1:0] o_granted_index;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int cycles;

    // commands in flight, and headers granted but not yet freed
    logic cmds_in_flight[$];
    int   live_blocks[$];

    boundary_tag_allocator_unit #(.MEM_WORDS(MEM_WORDS), .WORD_BYTES(16)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_request_bytes(i_request_bytes),
        .i_block_index  (i_block_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_granted_index(o_granted_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    btag_checker #(.MEM_WORDS(MEM_WORDS), .WORD_BYTES(16)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_request_bytes(i_request_bytes),
        .i_block_index  (i_block_index),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_granted_index(o_granted_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop on a hung handshake
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int held;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                for (held = 0; held < 400; held++) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // learn granted headers so that frees name real blocks
    always @(posedge i_clk) begin
        logic c;
        if (i_rst_n && o_out_valid && i_out_ready && cmds_in_flight.size() > 0) begin
            c = cmds_in_flight.pop_front();
            if (c == CMD_ALLOC && o_status == STATUS_DONE) live_blocks.push_back(o_granted_index);
        end
    end

    // offer one word; called and returns at a falling edge
    task automatic send_word(input logic c, input int bytes, input int idx);
        while ($urandom_range(99) < tx_idle_pct) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_cmd = c;
        i_request_bytes = BYTES_W'(bytes);
        i_block_index = INDEX_W'(idx);
        do @(posedge i_clk); while (!o_in_ready);
        cmds_in_flight.push_back(c);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk); while (pending != 0 || cmds_in_flight.size() != 0);
    endtask

    task automatic write_threshold(input int v);
        i_cfg_we = 1'b1;
        i_cfg_wdata = CFG_W'(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // allocate and wait, so the next directed free knows the header
    task automatic alloc_now(input int bytes);
        send_word(CMD_ALLOC, bytes, $urandom_range(1023));
        drain();
    endtask

    task automatic free_now(input int pos);
        int idx;
        idx = live_blocks[pos];
        live_blocks.delete(pos);
        send_word(CMD_FREE, $urandom_range(32767), idx);
        drain();
    endtask

    function automatic int pick_bytes();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(300);
        if (r < 92) return $urandom_range(4000);
        if (r < 97) return $urandom_range(16400);
        return $urandom_range(32767);
    endfunction

    initial begin
        int thr;
        int pos;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_ALLOC;
        i_request_bytes = '0;
        i_block_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: tiny, odd and oversized requests, then every merge shape
        write_threshold(8);
        alloc_now(0);
        alloc_now(16);
        alloc_now(17);
        alloc_now(100);
        alloc_now(32767);
        alloc_now(16384);
        if (live_blocks.size() >= 4) begin
            free_now(1);
            free_now(1);
            free_now(1);
            free_now(0);
        end
        while (live_blocks.size() > 0) free_now(0);
        // whole store in one grant empties the list; next allocate must fail
        alloc_now(16352);
        alloc_now(0);
        while (live_blocks.size() > 0) free_now(0);
        // nothing absorbed: any leftover splits
        write_threshold(0);
        alloc_now(16320);
        alloc_now(0);
        alloc_now(0);
        while (live_blocks.size() > 0) free_now($urandom_range(live_blocks.size() - 1));

        // random: four threshold settings with different idling
        for (int seg = 0; seg < 4; seg++) begin
            drain();
            case (seg)
                0: thr = 8;
                1: thr = 0;
                2: thr = 1024;
                default: thr = $urandom_range(1024);
            endcase
            write_threshold(thr);
            tx_idle_pct = (seg == 0) ? 18 : (seg == 1) ? 84 : 0;
            rx_idle_pct = (seg == 0) ? 84 : (seg == 1) ? 18 : 0;
            for (int k = 0; k < 350; k++) begin
                if (seg == 2 && k == 100) hold_req = 1'b1;
                if (seg == 3 && k >= 175) begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end else if (seg == 3 && k >= 60) begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 30;
                end
                if (live_blocks.size() > 0 && $urandom_range(99) < 45) begin
                    pos = $urandom_range(live_blocks.size() - 1);
                    send_word(CMD_FREE, $urandom_range(32767), live_blocks[pos]);
                    live_blocks.delete(pos);
                end else begin
                    send_word(CMD_ALLOC, pick_bytes(), $urandom_range(1023));
                end
            end
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
sv/btag_pkg.sv
sv/btag_ram.sv
sv/boundary_tag_allocator_unit.sv
sv/btag_chk.sv
bench/btag_checker.sv
bench/tb.sv
